>>> rtl/evfg_pkg.sv
package evfg_pkg;

    // Default configuration of the block.
    localparam int MAX_WAITERS_DEF = 16;
    localparam int FLAG_BITS_DEF   = 32;

    // Fixed field widths at the ports.
    localparam int FUNC_W  = 2;
    localparam int TASK_W  = 4;
    localparam int MODE_W  = 3;
    localparam int MASK_W  = 32;
    localparam int STAT_W  = 3;
    localparam int COUNT_W = 5;

    // Bit positions inside the mode field.
    localparam int MODE_CLEAR   = 0;
    localparam int MODE_ALL     = 1;
    localparam int MODE_CONSUME = 2;

    typedef enum logic [FUNC_W-1:0] {
        FN_WAIT = 2'd0,
        FN_POST = 2'd1,
        FN_READ = 2'd2,
        FN_INIT = 2'd3
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        ST_NOW     = 3'd0,
        ST_QUEUED  = 3'd1,
        ST_WOKEN   = 3'd2,
        ST_BADMASK = 3'd3,
        ST_FULL    = 3'd4,
        ST_FLUSHED = 3'd5,
        ST_DONE    = 3'd6
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_TEST,
        S_WAKE_RD,
        S_WAKE_TEST,
        S_FLUSH_RD,
        S_FLUSH_OUT
    } t_state;

endpackage

>>> rtl/evfg_ram.sv
module evfg_ram #(
    parameter int WIDTH = 39,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/evfg_match.sv
module evfg_match import evfg_pkg::*; #(
    parameter int FLAG_BITS = FLAG_BITS_DEF
) (
    input  logic [FLAG_BITS-1:0] i_flags,
    input  logic [FLAG_BITS-1:0] i_mask,
    input  logic [MODE_W-1:0]    i_mode,
    input  logic [FLAG_BITS-1:0] i_cons_flags,
    output logic [FLAG_BITS-1:0] o_bits,
    output logic                 o_hit,
    output logic [FLAG_BITS-1:0] o_cons_flags
);

    // In clear mode the watched bits are those that are clear in the flags.
    always_comb begin
        o_bits = i_mode[MODE_CLEAR] ? (~i_flags & i_mask) : (i_flags & i_mask);
        o_hit  = i_mode[MODE_ALL] ? (o_bits == i_mask) : (o_bits != '0);
        if (!i_mode[MODE_CONSUME]) begin
            o_cons_flags = i_cons_flags;
        end else if (i_mode[MODE_CLEAR]) begin
            o_cons_flags = i_cons_flags | o_bits;
        end else begin
            o_cons_flags = i_cons_flags & ~o_bits;
        end
    end

endmodule

>>> rtl/event_flag_group_top.sv
// Event flag group with a first-in first-out table of waiting tasks.
// A transaction is taken when i_start is high and o_busy is low; i_func picks
// wait, post, read, or init. Each result appears for exactly one cycle with
// o_res_valid high, and o_last marks the final result of a transaction. The
// receiver cannot stall; every result must be captured in its cycle.
// Wait and read finish at the accepting edge: their single result shows in
// the next cycle with o_busy already low, so one may be taken every cycle.
// A post runs two passes over the N queued waiters through one shared match
// unit and the waiter memory, which has one write port and one read port;
// in each pass every entry is read, then tested. The first pass gathers the
// final flags and kept count, the second reports the woken tasks and
// compacts the survivors.
// Reset clears the flag register and empties the waiter table; no results
// are pending afterwards and the memory contents are left as they are.
module event_flag_group_top import evfg_pkg::*; #(
    parameter int MAX_WAITERS = MAX_WAITERS_DEF,
    parameter int FLAG_BITS   = FLAG_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic [FUNC_W-1:0]  i_func,
    input  logic [TASK_W-1:0]  i_task_id,
    input  logic [MODE_W-1:0]  i_mode,
    input  logic [MASK_W-1:0]  i_mask,
    output logic               o_res_valid,
    output logic [TASK_W-1:0]  o_task_id_res,
    output logic [STAT_W-1:0]  o_status,
    output logic [MASK_W-1:0]  o_result_bits,
    output logic [MASK_W-1:0]  o_flag_word,
    output logic [COUNT_W-1:0] o_waiter_count,
    output logic               o_last
);

    localparam int CW  = $clog2(MAX_WAITERS + 1);
    localparam int IW  = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
    localparam int EW  = TASK_W + MODE_W + FLAG_BITS;
    localparam int MW  = (FLAG_BITS < MASK_W) ? FLAG_BITS : MASK_W;
    localparam int CMW = (CW < COUNT_W) ? CW : COUNT_W;

    t_state               r_state, n_state;
    logic [FLAG_BITS-1:0] r_flags, n_flags;
    logic [FLAG_BITS-1:0] r_posted, n_posted;
    logic [FLAG_BITS-1:0] r_next, n_next;
    logic [CW-1:0]        r_qlen, n_qlen;
    logic [CW-1:0]        r_idx, n_idx;
    logic [CW-1:0]        r_keep, n_keep;
    logic [CW-1:0]        r_wptr, n_wptr;

    logic                 r_res_valid;
    logic [TASK_W-1:0]    r_res_task;
    t_status              r_res_status;
    logic [FLAG_BITS-1:0] r_res_bits;
    logic [FLAG_BITS-1:0] r_res_flags;
    logic [CW-1:0]        r_res_count;
    logic                 r_res_last;

    logic                 e_valid;
    logic [TASK_W-1:0]    e_task;
    t_status              e_status;
    logic [FLAG_BITS-1:0] e_bits;
    logic [FLAG_BITS-1:0] e_flags;
    logic [CW-1:0]        e_count;
    logic                 e_last;

    logic [FLAG_BITS-1:0] mask_fb;
    logic                 accept;

    logic                 we;
    logic [IW-1:0]        waddr;
    logic [EW-1:0]        wdata;
    logic [EW-1:0]        rd_data;
    logic [FLAG_BITS-1:0] rd_mask;
    logic [MODE_W-1:0]    rd_mode;
    logic [TASK_W-1:0]    rd_task;

    logic [FLAG_BITS-1:0] m_flags;
    logic [FLAG_BITS-1:0] m_mask;
    logic [MODE_W-1:0]    m_mode;
    logic [FLAG_BITS-1:0] m_cons_in;
    logic [FLAG_BITS-1:0] m_bits;
    logic                 m_hit;
    logic [FLAG_BITS-1:0] m_cons_out;

    always_comb begin
        mask_fb = '0;
        mask_fb[MW-1:0] = i_mask[MW-1:0];
    end

    assign accept  = i_start && (r_state == S_IDLE);
    assign o_busy  = (r_state != S_IDLE);

    assign rd_mask = rd_data[FLAG_BITS-1:0];
    assign rd_mode = rd_data[FLAG_BITS +: MODE_W];
    assign rd_task = rd_data[FLAG_BITS + MODE_W +: TASK_W];

    evfg_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_WAITERS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (r_idx[IW-1:0]),
        .o_rdata (rd_data)
    );

    // The match unit tests a new wait against the flags when idle, and a
    // stored waiter against the posted word during a post.
    always_comb begin
        if (r_state == S_IDLE) begin
            m_flags   = r_flags;
            m_mask    = mask_fb;
            m_mode    = i_mode;
            m_cons_in = r_flags;
        end else begin
            m_flags   = r_posted;
            m_mask    = rd_mask;
            m_mode    = rd_mode;
            m_cons_in = r_next;
        end
    end

    evfg_match #(
        .FLAG_BITS (FLAG_BITS)
    ) u_match (
        .i_flags      (m_flags),
        .i_mask       (m_mask),
        .i_mode       (m_mode),
        .i_cons_flags (m_cons_in),
        .o_bits       (m_bits),
        .o_hit        (m_hit),
        .o_cons_flags (m_cons_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_flags     <= '0;
            r_qlen      <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_flags     <= n_flags;
            r_qlen      <= n_qlen;
            r_res_valid <= e_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_posted     <= n_posted;
        r_next       <= n_next;
        r_idx        <= n_idx;
        r_keep       <= n_keep;
        r_wptr       <= n_wptr;
        r_res_task   <= e_task;
        r_res_status <= e_status;
        r_res_bits   <= e_bits;
        r_res_flags  <= e_flags;
        r_res_count  <= e_count;
        r_res_last   <= e_last;
    end

    always_comb begin
        n_state  = r_state;
        n_flags  = r_flags;
        n_posted = r_posted;
        n_next   = r_next;
        n_qlen   = r_qlen;
        n_idx    = r_idx;
        n_keep   = r_keep;
        n_wptr   = r_wptr;
        we       = 1'b0;
        waddr    = r_wptr[IW-1:0];
        wdata    = rd_data;
        e_valid  = 1'b0;
        e_task   = '0;
        e_status = ST_DONE;
        e_bits   = '0;
        e_flags  = r_flags;
        e_count  = r_qlen;
        e_last   = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (t_func'(i_func))
                        FN_WAIT: begin
                            e_valid = 1'b1;
                            e_last  = 1'b1;
                            e_task  = i_task_id;
                            if (mask_fb == '0) begin
                                e_status = ST_BADMASK;
                            end else if (m_hit) begin
                                n_flags  = m_cons_out;
                                e_status = ST_NOW;
                                e_bits   = m_bits;
                            end else if (r_qlen == CW'(MAX_WAITERS)) begin
                                e_status = ST_FULL;
                            end else begin
                                we       = 1'b1;
                                waddr    = r_qlen[IW-1:0];
                                wdata    = {i_task_id, i_mode, mask_fb};
                                n_qlen   = r_qlen + 1'b1;
                                e_status = ST_QUEUED;
                            end
                            e_flags = n_flags;
                            e_count = n_qlen;
                        end
                        FN_POST: begin
                            if (mask_fb == '0) begin
                                e_valid  = 1'b1;
                                e_last   = 1'b1;
                                e_status = ST_BADMASK;
                            end else begin
                                n_posted = i_mode[MODE_CLEAR] ? (r_flags & ~mask_fb)
                                                              : (r_flags | mask_fb);
                                n_next   = n_posted;
                                n_idx    = '0;
                                n_keep   = '0;
                                n_state  = S_SCAN_RD;
                            end
                        end
                        FN_READ: begin
                            e_valid = 1'b1;
                            e_last  = 1'b1;
                        end
                        FN_INIT: begin
                            n_flags = mask_fb;
                            n_idx   = '0;
                            n_state = S_FLUSH_RD;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN_RD: begin
                if (r_idx == r_qlen) begin
                    // Final flags and kept count are known from here on.
                    n_flags = r_next;
                    n_idx   = '0;
                    n_wptr  = '0;
                    n_state = S_WAKE_RD;
                end else begin
                    n_state = S_SCAN_TEST;
                end
            end
            S_SCAN_TEST: begin
                if (m_hit) begin
                    n_next = m_cons_out;
                end else begin
                    n_keep = r_keep + 1'b1;
                end
                n_idx   = r_idx + 1'b1;
                n_state = S_SCAN_RD;
            end
            S_WAKE_RD: begin
                if (r_idx == r_qlen) begin
                    n_qlen  = r_keep;
                    e_valid = 1'b1;
                    e_last  = 1'b1;
                    e_count = r_keep;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_WAKE_TEST;
                end
            end
            S_WAKE_TEST: begin
                if (m_hit) begin
                    e_valid  = 1'b1;
                    e_task   = rd_task;
                    e_status = ST_WOKEN;
                    e_bits   = m_bits;
                    e_count  = r_keep;
                end else begin
                    // Survivors move down in order; the write never passes the read.
                    we     = 1'b1;
                    waddr  = r_wptr[IW-1:0];
                    n_wptr = r_wptr + 1'b1;
                end
                n_idx   = r_idx + 1'b1;
                n_state = S_WAKE_RD;
            end
            S_FLUSH_RD: begin
                if (r_idx == r_qlen) begin
                    n_qlen  = '0;
                    e_valid = 1'b1;
                    e_last  = 1'b1;
                    e_count = '0;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_FLUSH_OUT;
                end
            end
            S_FLUSH_OUT: begin
                e_valid  = 1'b1;
                e_task   = rd_task;
                e_status = ST_FLUSHED;
                e_count  = '0;
                n_idx    = r_idx + 1'b1;
                n_state  = S_FLUSH_RD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_res_valid    = r_res_valid;
        o_task_id_res  = r_res_task;
        o_status       = r_res_status;
        o_last         = r_res_last;
        o_result_bits  = '0;
        o_result_bits[MW-1:0] = r_res_bits[MW-1:0];
        o_flag_word    = '0;
        o_flag_word[MW-1:0] = r_res_flags[MW-1:0];
        o_waiter_count = '0;
        o_waiter_count[CMW-1:0] = r_res_count[CMW-1:0];
    end

endmodule

>>> rtl/evfg_checker.sv
module evfg_checker import evfg_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_start,
    input logic               o_busy,
    input logic [FUNC_W-1:0]  i_func,
    input logic               o_res_valid,
    input logic [STAT_W-1:0]  o_status,
    input logic [MASK_W-1:0]  o_result_bits,
    input logic               o_last
);

    // An idle block with no new transaction produces nothing.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_busy && !i_start |=> !o_res_valid)
        else $error("result without a transaction");

    a_read_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy && (i_func == FN_READ)
        |=> o_res_valid && o_last && (o_status == ST_DONE))
        else $error("read did not complete in one cycle");

    // The final result always coincides with the block becoming free again.
    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_last |-> !o_busy)
        else $error("busy after the final result");

    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_last |-> o_busy)
        else $error("intermediate result while idle");

    a_err_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && ((o_status == ST_BADMASK) || (o_status == ST_FULL)
                        || (o_status == ST_FLUSHED) || (o_status == ST_DONE))
        |-> (o_result_bits == '0))
        else $error("nonzero bits on a result without a match");

endmodule

bind event_flag_group_top evfg_checker u_evfg_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_start       (i_start),
    .o_busy        (o_busy),
    .i_func        (i_func),
    .o_res_valid   (o_res_valid),
    .o_status      (o_status),
    .o_result_bits (o_result_bits),
    .o_last        (o_last)
);
